// ===== rtl/lsi_pkg.sv =====
// Shared constants, codes and helpers for the line and sphere intersection core.
`timescale 1ns / 1ps

package lsi_pkg;

   localparam int RADIUS_WIDTH = 31;
   localparam int MUL_STEPS    = 4;
   localparam int MUL_LAT      = MUL_STEPS + 2;

   localparam logic [1:0] HIT_NONE = 2'd0;
   localparam logic [1:0] HIT_ONE  = 2'd1;
   localparam logic [1:0] HIT_TWO  = 2'd2;

   function automatic int max_int(input int lhs, input int rhs);
      return (lhs > rhs) ? lhs : rhs;
   endfunction

endpackage

// ===== rtl/lsi_delay.sv =====
// Enabled shift line that aligns side data with the arithmetic units.
`timescale 1ns / 1ps

module lsi_delay
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
)
(
   input  logic             clock,
   input  logic             step_en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (step_en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

// ===== rtl/lsi_mul.sv =====
// Pipelined signed multiplier, one digit of the second operand per stage.
`timescale 1ns / 1ps

module lsi_mul
   import lsi_pkg::*;
#(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 32
)
(
   input  logic                                clock,
   input  logic                                step_en,
   input  logic signed [A_WIDTH-1:0]           op_a,
   input  logic signed [B_WIDTH-1:0]           op_b,
   output logic signed [A_WIDTH+B_WIDTH-1:0]   product
);

   localparam int DIG  = (B_WIDTH + MUL_STEPS - 1) / MUL_STEPS;
   localparam int BPAD = DIG * MUL_STEPS;
   localparam int PW   = A_WIDTH + B_WIDTH;

   logic [A_WIDTH-1:0] mag_a_ff [MUL_STEPS];
   logic [BPAD-1:0]    mag_b_ff [MUL_STEPS];
   logic [PW-1:0]      acc_ff   [1:MUL_STEPS];
   logic               neg_ff   [MUL_STEPS+1];
   logic [A_WIDTH-1:0] mag_a;
   logic [B_WIDTH-1:0] mag_b;

   assign mag_a = op_a[A_WIDTH-1] ? A_WIDTH'(-op_a) : A_WIDTH'(op_a);
   assign mag_b = op_b[B_WIDTH-1] ? B_WIDTH'(-op_b) : B_WIDTH'(op_b);

   always_ff @(posedge clock) begin
      if (step_en) begin
         mag_a_ff[0] <= mag_a;
         mag_b_ff[0] <= BPAD'(mag_b);
         neg_ff[0]   <= op_a[A_WIDTH-1] ^ op_b[B_WIDTH-1];
      end
   end

   for (genvar k = 1; k <= MUL_STEPS; k++) begin : g_step
      logic [A_WIDTH+DIG-1:0] part;
      logic [PW-1:0]          shifted;

      assign part    = mag_a_ff[k-1] * mag_b_ff[k-1][DIG-1:0];
      assign shifted = PW'(part) << ((k - 1) * DIG);

      always_ff @(posedge clock) begin
         if (step_en) begin
            neg_ff[k] <= neg_ff[k-1];
         end
      end

      if (k == 1) begin : g_first
         always_ff @(posedge clock) begin
            if (step_en) begin
               acc_ff[k] <= shifted;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (step_en) begin
               acc_ff[k] <= acc_ff[k-1] + shifted;
            end
         end
      end

      if (k < MUL_STEPS) begin : g_fwd
         always_ff @(posedge clock) begin
            if (step_en) begin
               mag_a_ff[k] <= mag_a_ff[k-1];
               mag_b_ff[k] <= mag_b_ff[k-1] >> DIG;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         product <= neg_ff[MUL_STEPS] ? PW'(-acc_ff[MUL_STEPS]) : acc_ff[MUL_STEPS];
      end
   end

endmodule

// ===== rtl/lsi_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, rounded down.
`timescale 1ns / 1ps

module lsi_isqrt
#(
   parameter int ROOT_WIDTH = 67
)
(
   input  logic                    clock,
   input  logic                    step_en,
   input  logic [2*ROOT_WIDTH-1:0] radicand,
   output logic [ROOT_WIDTH-1:0]   root
);

   localparam int XW = 2 * ROOT_WIDTH;

   logic [XW-1:0] op_ff  [1:ROOT_WIDTH-1];
   logic [XW-1:0] res_ff [1:ROOT_WIDTH];

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_bit
      localparam int SH = XW - 2 - 2 * k;
      logic [XW-1:0] op_prev;
      logic [XW-1:0] res_prev;
      logic [XW-1:0] one_bit;
      logic [XW-1:0] trial;
      logic          take;

      if (k == 0) begin : g_head
         assign op_prev  = radicand;
         assign res_prev = '0;
      end else begin : g_body
         assign op_prev  = op_ff[k];
         assign res_prev = res_ff[k];
      end

      assign one_bit = {{(XW-1){1'b0}}, 1'b1} << SH;
      assign trial   = res_prev + one_bit;
      assign take    = op_prev >= trial;

      always_ff @(posedge clock) begin
         if (step_en) begin
            res_ff[k+1] <= take ? (res_prev >> 1) + one_bit : res_prev >> 1;
         end
      end

      if (k < ROOT_WIDTH - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (step_en) begin
               op_ff[k+1] <= take ? op_prev - trial : op_prev;
            end
         end
      end
   end

   assign root = res_ff[ROOT_WIDTH][ROOT_WIDTH-1:0];

endmodule

// ===== rtl/lsi_div.sv =====
// Pipelined restoring divider with a bounded quotient and an overflow flag.
`timescale 1ns / 1ps

module lsi_div
   import lsi_pkg::*;
#(
   parameter int NUM_WIDTH = 103,
   parameter int DEN_WIDTH = 67,
   parameter int QUO_WIDTH = 33
)
(
   input  logic                 clock,
   input  logic                 step_en,
   input  logic [NUM_WIDTH-1:0] numer,
   input  logic [DEN_WIDTH-1:0] denom,
   output logic [QUO_WIDTH-1:0] quotient,
   output logic                 overflow
);

   localparam int XW = max_int(NUM_WIDTH, DEN_WIDTH + QUO_WIDTH);

   logic [XW-1:0]        rem_ff [QUO_WIDTH];
   logic [DEN_WIDTH-1:0] den_ff [QUO_WIDTH];
   logic                 ovf_ff [QUO_WIDTH+1];
   logic [QUO_WIDTH-1:0] quo_ff [1:QUO_WIDTH];

   // quotient that does not fit is flagged up front
   always_ff @(posedge clock) begin
      if (step_en) begin
         rem_ff[0] <= XW'(numer);
         den_ff[0] <= denom;
         ovf_ff[0] <= XW'(numer) >= (XW'(denom) << QUO_WIDTH);
      end
   end

   for (genvar j = 1; j <= QUO_WIDTH; j++) begin : g_bit
      logic [XW-1:0] trial;
      logic          take;

      assign trial = XW'(den_ff[j-1]) << (QUO_WIDTH - j);
      assign take  = rem_ff[j-1] >= trial;

      always_ff @(posedge clock) begin
         if (step_en) begin
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end

      if (j == 1) begin : g_first
         always_ff @(posedge clock) begin
            if (step_en) begin
               quo_ff[j] <= QUO_WIDTH'(take);
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (step_en) begin
               quo_ff[j] <= {quo_ff[j-1][QUO_WIDTH-2:0], take};
            end
         end
      end

      if (j < QUO_WIDTH) begin : g_fwd
         always_ff @(posedge clock) begin
            if (step_en) begin
               rem_ff[j] <= take ? rem_ff[j-1] - trial : rem_ff[j-1];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign quotient = quo_ff[QUO_WIDTH];
   assign overflow = ovf_ff[QUO_WIDTH];

endmodule

// ===== rtl/line_sphere_intersection_core.sv =====
// Top level: line through two points intersected with a sphere at the origin.
//
//   channel  direction  handshake            beat
//   req_     in         req_valid/req_stall  start and end point
//   rsp_     out        rsp_valid/rsp_stall  hit count and two hit points
//   csr_     in         csr_wr_en            sphere radius
//
// One beat accepted per cycle while the result is not stalled. The square root
// (67 root bits at the defaults) yields one root bit per stage, and the divider
// yields one quotient bit per stage; these two units make up most of the pipeline.
// Reset clears the valid bits and sets the radius to 1.0.
// A stalled result freezes the whole pipeline; nothing is dropped.
`timescale 1ns / 1ps

module line_sphere_intersection_core
   import lsi_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_hit_count,
   output logic signed [COORD_WIDTH-1:0] rsp_first_hit_x,
   output logic signed [COORD_WIDTH-1:0] rsp_first_hit_y,
   output logic signed [COORD_WIDTH-1:0] rsp_first_hit_z,
   output logic signed [COORD_WIDTH-1:0] rsp_second_hit_x,
   output logic signed [COORD_WIDTH-1:0] rsp_second_hit_y,
   output logic signed [COORD_WIDTH-1:0] rsp_second_hit_z,
   input  logic                          csr_wr_en,
   input  logic [RADIUS_WIDTH-1:0]       csr_wr_data
);

   localparam int W     = COORD_WIDTH;
   localparam int DW    = W + 1;
   localparam int AWID  = 2 * W + 3;
   localparam int HW    = 2 * W + 3;
   localparam int CW    = max_int(2 * W, 2 * RADIUS_WIDTH) + 2;
   localparam int ROPW  = RADIUS_WIDTH + 1;
   localparam int DSW   = max_int(2 * HW, AWID + CW) + 1;
   localparam int RW    = DSW / 2;
   localparam int TW    = max_int(HW, RW + 1) + 1;
   localparam int NW    = DW + TW;
   localparam int NUMW  = NW + 1;
   localparam int QB    = W + 1;
   localparam int W3    = W + 3;
   localparam int ML    = MUL_LAT;
   localparam int S4    = 2 * ML + RW + 3;
   localparam int LAST  = 3 * ML + RW + QB + 6;
   localparam int PDW   = 1 + 3 * W + 3 * DW;
   localparam int FINW  = 2 + 3 * W;

   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = RADIUS_WIDTH'(1) << FRAC_BITS;
   localparam logic signed [W-1:0] COORD_HI = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] COORD_LO = {1'b1, {(W-1){1'b0}}};

   logic                    step_en;
   logic [LAST:0]           vld_ff;
   logic [LAST:0]           vld_in;
   logic [RADIUS_WIDTH-1:0] radius_ff;
   logic signed [ROPW-1:0]  radius_op;

   assign step_en   = !vld_ff[LAST] || !rsp_stall;
   assign req_stall = !step_en;
   assign rsp_valid = vld_ff[LAST];
   assign vld_in    = {vld_ff[LAST-1:0], req_valid};
   assign radius_op = {1'b0, radius_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         radius_ff <= RADIUS_RESET;
      end else begin
         if (step_en) begin
            vld_ff <= vld_in;
         end
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
   end

   // stage 0: points and direction
   logic signed [W-1:0]  start_v [3];
   logic signed [W-1:0]  end_v   [3];
   logic signed [W-1:0]  p0_ff   [3];
   logic signed [DW-1:0] d0_ff   [3];
   logic                 az0_ff;

   always_comb begin
      start_v[0] = req_start_x;
      start_v[1] = req_start_y;
      start_v[2] = req_start_z;
      end_v[0]   = req_end_x;
      end_v[1]   = req_end_y;
      end_v[2]   = req_end_z;
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         for (int i = 0; i < 3; i++) begin
            p0_ff[i] <= start_v[i];
            d0_ff[i] <= DW'(end_v[i]) - DW'(start_v[i]);
         end
         az0_ff <= (start_v[0] == end_v[0]) && (start_v[1] == end_v[1]) &&
                   (start_v[2] == end_v[2]);
      end
   end

   // dot products
   logic signed [2*DW-1:0]   dd_p [3];
   logic signed [DW+W-1:0]   pd_p [3];
   logic signed [2*W-1:0]    pp_p [3];
   logic signed [2*ROPW-1:0] rr_p;

   for (genvar g = 0; g < 3; g++) begin : g_dot
      lsi_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_dd (
         .clock(clock), .step_en(step_en), .op_a(d0_ff[g]), .op_b(d0_ff[g]),
         .product(dd_p[g]));
      lsi_mul #(.A_WIDTH(DW), .B_WIDTH(W)) u_pd (
         .clock(clock), .step_en(step_en), .op_a(d0_ff[g]), .op_b(p0_ff[g]),
         .product(pd_p[g]));
      lsi_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_pp (
         .clock(clock), .step_en(step_en), .op_a(p0_ff[g]), .op_b(p0_ff[g]),
         .product(pp_p[g]));
   end

   lsi_mul #(.A_WIDTH(ROPW), .B_WIDTH(ROPW)) u_rr (
      .clock(clock), .step_en(step_en), .op_a(radius_op), .op_b(radius_op),
      .product(rr_p));

   // stage 2: quadratic coefficients
   logic signed [AWID-1:0] a_s2_ff;
   logic signed [HW-1:0]   h_s2_ff;
   logic signed [CW-1:0]   c_s2_ff;

   always_ff @(posedge clock) begin
      if (step_en) begin
         a_s2_ff <= AWID'(dd_p[0]) + AWID'(dd_p[1]) + AWID'(dd_p[2]);
         h_s2_ff <= HW'(pd_p[0]) + HW'(pd_p[1]) + HW'(pd_p[2]);
         c_s2_ff <= CW'(pp_p[0]) + CW'(pp_p[1]) + CW'(pp_p[2]) - CW'(rr_p);
      end
   end

   logic signed [2*HW-1:0]    hh_p;
   logic signed [CW+AWID-1:0] ac_p;

   lsi_mul #(.A_WIDTH(HW), .B_WIDTH(HW)) u_hh (
      .clock(clock), .step_en(step_en), .op_a(h_s2_ff), .op_b(h_s2_ff),
      .product(hh_p));
   lsi_mul #(.A_WIDTH(CW), .B_WIDTH(AWID)) u_ac (
      .clock(clock), .step_en(step_en), .op_a(c_s2_ff), .op_b(a_s2_ff),
      .product(ac_p));

   logic signed [HW-1:0] h_dly;
   logic [AWID-1:0]      a_dly;

   lsi_delay #(.WIDTH(HW), .DEPTH(ML + RW + 1)) u_h_dly (
      .clock(clock), .step_en(step_en), .din(h_s2_ff), .dout(h_dly));
   lsi_delay #(.WIDTH(AWID), .DEPTH(2 * ML + RW + 2)) u_a_dly (
      .clock(clock), .step_en(step_en), .din(a_s2_ff), .dout(a_dly));

   // stage 3: discriminant and root
   logic signed [DSW-1:0] disc_s3_ff;
   logic [2*RW-1:0]       sq_in;
   logic [RW-1:0]         sq_root;
   logic [1:0]            flag_in;
   logic [1:0]            flag_dly;

   always_ff @(posedge clock) begin
      if (step_en) begin
         disc_s3_ff <= DSW'(hh_p) - DSW'(ac_p);
      end
   end

   assign sq_in   = disc_s3_ff[DSW-1] ? '0 : disc_s3_ff[2*RW-1:0];
   assign flag_in = {disc_s3_ff[DSW-1], disc_s3_ff == '0};

   lsi_isqrt #(.ROOT_WIDTH(RW)) u_sqrt (
      .clock(clock), .step_en(step_en), .radicand(sq_in), .root(sq_root));

   lsi_delay #(.WIDTH(2), .DEPTH(RW)) u_flag_dly (
      .clock(clock), .step_en(step_en), .din(flag_in), .dout(flag_dly));

   logic [PDW-1:0]       pd_bus_in;
   logic [PDW-1:0]       pd_bus;
   logic signed [W-1:0]  pd_p_v [3];
   logic signed [DW-1:0] pd_d_v [3];

   always_comb begin
      pd_bus_in[PDW-1] = az0_ff;
      for (int i = 0; i < 3; i++) begin
         pd_bus_in[i*DW +: DW]          = d0_ff[i];
         pd_bus_in[3*DW + i*W +: W]     = p0_ff[i];
         pd_d_v[i]                      = pd_bus[i*DW +: DW];
         pd_p_v[i]                      = pd_bus[3*DW + i*W +: W];
      end
   end

   lsi_delay #(.WIDTH(PDW), .DEPTH(S4 - 1)) u_pd_dly (
      .clock(clock), .step_en(step_en), .din(pd_bus_in), .dout(pd_bus));

   // stage 4: root parameters and hit count
   logic signed [TW-1:0] h_t;
   logic signed [TW-1:0] s_t;
   logic signed [TW-1:0] t1_ff;
   logic signed [TW-1:0] t2_ff;
   logic signed [W-1:0]  p4_ff [3];
   logic signed [DW-1:0] d4_ff [3];
   logic [1:0]           cnt4_ff;
   logic [1:0]           cnt_in;

   assign h_t = TW'(h_dly);
   assign s_t = TW'(sq_root);

   always_comb begin
      if (pd_bus[PDW-1] || flag_dly[1]) begin
         cnt_in = HIT_NONE;
      end else if (flag_dly[0]) begin
         cnt_in = HIT_ONE;
      end else begin
         cnt_in = HIT_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         t1_ff   <= s_t - h_t;
         t2_ff   <= -h_t - s_t;
         cnt4_ff <= cnt_in;
         for (int i = 0; i < 3; i++) begin
            p4_ff[i] <= pd_p_v[i];
            d4_ff[i] <= pd_d_v[i];
         end
      end
   end

   // offsets along the line, numerators D_i * t
   logic signed [NW-1:0] n_all [6];

   for (genvar g = 0; g < 3; g++) begin : g_off
      lsi_mul #(.A_WIDTH(TW), .B_WIDTH(DW)) u_n1 (
         .clock(clock), .step_en(step_en), .op_a(t1_ff), .op_b(d4_ff[g]),
         .product(n_all[g]));
      lsi_mul #(.A_WIDTH(TW), .B_WIDTH(DW)) u_n2 (
         .clock(clock), .step_en(step_en), .op_a(t2_ff), .op_b(d4_ff[g]),
         .product(n_all[g+3]));
   end

   logic [FINW-1:0]      fin_bus_in;
   logic [FINW-1:0]      fin_bus;
   logic signed [W-1:0]  p_fin [3];
   logic [1:0]           cnt_fin;

   always_comb begin
      fin_bus_in[3*W +: 2] = cnt4_ff;
      for (int i = 0; i < 3; i++) begin
         fin_bus_in[i*W +: W] = p4_ff[i];
         p_fin[i]             = fin_bus[i*W +: W];
      end
      cnt_fin = fin_bus[3*W +: 2];
   end

   lsi_delay #(.WIDTH(FINW), .DEPTH(ML + QB + 2)) u_fin_dly (
      .clock(clock), .step_en(step_en), .din(fin_bus_in), .dout(fin_bus));

   // stage 5: rounded division operands
   logic [NW-1:0]   mag_v   [6];
   logic [NUMW-1:0] num5_ff [6];
   logic [AWID-1:0] den5_ff;
   logic [5:0]      sign5_ff;
   logic [5:0]      sign_fin;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         mag_v[k] = n_all[k][NW-1] ? NW'(-n_all[k]) : NW'(n_all[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         den5_ff <= a_dly << 1;
         for (int k = 0; k < 6; k++) begin
            num5_ff[k]  <= (NUMW'(mag_v[k]) << 1) + NUMW'(a_dly);
            sign5_ff[k] <= n_all[k][NW-1];
         end
      end
   end

   lsi_delay #(.WIDTH(6), .DEPTH(QB + 1)) u_sign_dly (
      .clock(clock), .step_en(step_en), .din(sign5_ff), .dout(sign_fin));

   logic [QB-1:0] quo [6];
   logic          ovf [6];

   for (genvar k = 0; k < 6; k++) begin : g_div
      lsi_div #(.NUM_WIDTH(NUMW), .DEN_WIDTH(AWID), .QUO_WIDTH(QB)) u_div (
         .clock(clock), .step_en(step_en), .numer(num5_ff[k]), .denom(den5_ff),
         .quotient(quo[k]), .overflow(ovf[k]));
   end

   // final: add offset to start point and saturate
   logic signed [W3-1:0] qs_v  [6];
   logic signed [W3-1:0] sum_v [6];
   logic signed [W-1:0]  hit_v [6];

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         qs_v[k] = W3'(quo[k]);
         if (sign_fin[k]) begin
            qs_v[k] = -qs_v[k];
         end
         sum_v[k] = W3'(p_fin[k % 3]) + qs_v[k];
         if (ovf[k]) begin
            hit_v[k] = sign_fin[k] ? COORD_LO : COORD_HI;
         end else if (sum_v[k] > W3'(COORD_HI)) begin
            hit_v[k] = COORD_HI;
         end else if (sum_v[k] < W3'(COORD_LO)) begin
            hit_v[k] = COORD_LO;
         end else begin
            hit_v[k] = sum_v[k][W-1:0];
         end
      end
   end

   logic [1:0]          rsp_cnt_ff;
   logic signed [W-1:0] rsp_hit_ff [6];

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_cnt_ff <= cnt_fin;
         for (int k = 0; k < 3; k++) begin
            rsp_hit_ff[k]   <= (cnt_fin != HIT_NONE) ? hit_v[k] : '0;
            rsp_hit_ff[k+3] <= (cnt_fin == HIT_TWO) ? hit_v[k+3] : '0;
         end
      end
   end

   assign rsp_hit_count    = rsp_cnt_ff;
   assign rsp_first_hit_x  = rsp_hit_ff[0];
   assign rsp_first_hit_y  = rsp_hit_ff[1];
   assign rsp_first_hit_z  = rsp_hit_ff[2];
   assign rsp_second_hit_x = rsp_hit_ff[3];
   assign rsp_second_hit_y = rsp_hit_ff[4];
   assign rsp_second_hit_z = rsp_hit_ff[5];

endmodule
